// File: design/hsv_to_rgb_convert_assert.svh
// Assertion macros for the HSV to RGB converter.
// No dependencies; included by design/hsv_to_rgb_convert.sv.
`ifndef HSV_TO_RGB_CONVERT_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_ASSERT_SVH

// Condition must hold on every clock edge outside reset
`define HSV_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("hsv_to_rgb_convert: check failed");

// Consequent must hold in the same cycle as the antecedent
`define HSV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv_to_rgb_convert: check failed");

// Consequent must hold in the cycle after the antecedent
`define HSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv_to_rgb_convert: check failed");

`endif

// File: design/hsv2rgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// No dependencies; used by design/hsv_to_rgb_convert.sv.
package hsv2rgb_pkg;

   // Input pixel word
   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } req_word_type;

   // Output pixel word
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_word_type;

   // Hexcone sector of the hue
   typedef enum logic [2:0] {
      SECTOR_RED_UP    = 3'd0,
      SECTOR_GREEN_UP  = 3'd1,
      SECTOR_GREEN_DN  = 3'd2,
      SECTOR_BLUE_UP   = 3'd3,
      SECTOR_BLUE_DN   = 3'd4,
      SECTOR_RED_DN    = 3'd5
   } sector_type;

   // Whole degrees in a turn and in a sector
   localparam int unsigned DEG_TURN   = 360;
   localparam int unsigned DEG_SECTOR = 60;

   // Full scale of a channel byte
   localparam int unsigned FULL_SCALE = 255;

   // Divisor of the ramp channel after the hue fraction shift: 255 * 60
   localparam int unsigned RAMP_DIV = FULL_SCALE * DEG_SECTOR;

   // Reciprocals: floor(2^shift / divisor); estimate is exact or one low
   localparam logic [13:0] TURN_RECIP = 14'd11650;
   localparam int unsigned TURN_SHIFT = 22;
   localparam logic [16:0] LOW_RECIP  = 17'd65793;
   localparam int unsigned LOW_SHIFT  = 24;
   localparam logic [16:0] RAMP_RECIP = 17'd70179;
   localparam int unsigned RAMP_SHIFT = 30;

   // Width of whole degrees quotient and of the shifted ramp numerator
   localparam int unsigned TURN_QW = 8;
   localparam int unsigned RAMP_XW = 22;

endpackage

// File: design/hsv_to_rgb_convert.sv
// Throughput one pixel per cycle while rsp_stall is low.
// Seven register stages; each stage loads whenever it is empty or the one after it moves,
// so bubbles close up and req_stall only rises when all stages hold a word and rsp stalls.
// The multipliers (turn reciprocal, v*(255-s), low reciprocal, s*k, v*n, ramp reciprocal)
// each sit alone between two stages and set the clock.
// Reset: synchronous, clears the stage valid bits only; data registers are not reset.
// Top level of the HSV to RGB converter; depends on hsv2rgb_pkg and
// hsv_to_rgb_convert_assert.svh.
`include "hsv_to_rgb_convert_assert.svh"

module hsv_to_rgb_convert #(
   parameter int unsigned HUE_FRAC_BITS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hsv2rgb_pkg::req_word_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hsv2rgb_pkg::rsp_word_type rsp_data
);

   // Derived widths
   localparam int unsigned QW      = 16 - HUE_FRAC_BITS;
   localparam int unsigned FW      = (HUE_FRAC_BITS > 0) ? HUE_FRAC_BITS : 1;
   localparam int unsigned SEC_W   = hsv2rgb_pkg::DEG_SECTOR << HUE_FRAC_BITS;
   localparam int unsigned KW      = $clog2(SEC_W + 1);
   localparam int unsigned NW      = $clog2(hsv2rgb_pkg::FULL_SCALE * SEC_W + 1);
   localparam int unsigned PW      = NW + 8;
   localparam int unsigned XW      = hsv2rgb_pkg::RAMP_XW;
   localparam int unsigned TQW     = hsv2rgb_pkg::TURN_QW;
   localparam logic [15:0] HUE_MASK = 16'((32'd1 << HUE_FRAC_BITS) - 32'd1);

   localparam int unsigned TS = hsv2rgb_pkg::TURN_SHIFT;
   localparam int unsigned LS = hsv2rgb_pkg::LOW_SHIFT;
   localparam int unsigned RS = hsv2rgb_pkg::RAMP_SHIFT;

   // Stage valid bits and load enables; stage 7 is the output register
   logic [7:1] stage_vld_ff;
   logic [7:1] stage_vld_in;
   logic [7:1] stage_en;

   // Load enable ripples back from the output through full stages; an empty stage always loads
   always_comb begin
      stage_en[7] = !stage_vld_ff[7] || !rsp_stall;
      for (int i = 6; i >= 1; i--) begin
         stage_en[i] = !stage_vld_ff[i] || stage_en[i + 1];
      end
      stage_vld_in[1] = stage_en[1] ? req_valid : stage_vld_ff[1];
      for (int i = 2; i <= 7; i++) begin
         stage_vld_in[i] = stage_en[i] ? stage_vld_ff[i - 1] : stage_vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   assign req_stall = !stage_en[1];
   assign rsp_valid = stage_vld_ff[7];

   // ---------------- Stage 1: whole degrees and turn quotient estimate
   logic [QW-1:0]  q1_ff;
   logic [QW-1:0]  q1_in;
   logic [FW-1:0]  frac1_ff;
   logic [TQW-1:0] tq1_ff;
   logic [29:0]    tq_prod;
   logic [7:0]     s1_ff;
   logic [7:0]     v1_ff;

   assign q1_in   = QW'(req_data.hue >> HUE_FRAC_BITS);
   assign tq_prod = 30'(q1_in) * 30'(hsv2rgb_pkg::TURN_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         q1_ff    <= q1_in;
         frac1_ff <= FW'(req_data.hue & HUE_MASK);
         tq1_ff   <= tq_prod[TS+TQW-1:TS];
         s1_ff    <= req_data.saturation;
         v1_ff    <= req_data.brightness;
      end
   end

   // ---------------- Stage 2: degrees mod 360, and v*(255-s)
   logic [16:0] trem_wide;
   logic [9:0]  trem;
   logic [8:0]  qm2_in;
   logic [8:0]  qm2_ff;
   logic [FW-1:0] frac2_ff;
   logic [15:0] y2_ff;
   logic [7:0]  s2_ff;
   logic [7:0]  v2_ff;

   assign trem_wide = 17'(q1_ff) - 17'(tq1_ff) * 17'(hsv2rgb_pkg::DEG_TURN);
   assign trem      = trem_wide[9:0];
   assign qm2_in    = (trem >= 10'(hsv2rgb_pkg::DEG_TURN))
                      ? 9'(trem - 10'(hsv2rgb_pkg::DEG_TURN)) : trem[8:0];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         qm2_ff   <= qm2_in;
         frac2_ff <= frac1_ff;
         y2_ff    <= 16'(v1_ff) * 16'(8'(8'd255 - s1_ff));
         s2_ff    <= s1_ff;
         v2_ff    <= v1_ff;
      end
   end

   // ---------------- Stage 3: sector, reflected position, low estimate
   hsv2rgb_pkg::sector_type sec3_in;
   hsv2rgb_pkg::sector_type sec3_ff;
   logic [8:0]    sec_base;
   logic [5:0]    deg_in_sec;
   logic [KW-1:0] pos;
   logic [KW-1:0] k3_in;
   logic [KW-1:0] k3_ff;
   logic [32:0]   low_prod;
   logic [7:0]    lowq3_ff;
   logic [15:0]   y3_ff;
   logic [7:0]    s3_ff;
   logic [7:0]    v3_ff;

   // Sector from five constant compares
   always_comb begin
      priority if (qm2_ff >= 9'd300) begin
         sec3_in  = hsv2rgb_pkg::SECTOR_RED_DN;
         sec_base = 9'd300;
      end else if (qm2_ff >= 9'd240) begin
         sec3_in  = hsv2rgb_pkg::SECTOR_BLUE_DN;
         sec_base = 9'd240;
      end else if (qm2_ff >= 9'd180) begin
         sec3_in  = hsv2rgb_pkg::SECTOR_BLUE_UP;
         sec_base = 9'd180;
      end else if (qm2_ff >= 9'd120) begin
         sec3_in  = hsv2rgb_pkg::SECTOR_GREEN_DN;
         sec_base = 9'd120;
      end else if (qm2_ff >= 9'd60) begin
         sec3_in  = hsv2rgb_pkg::SECTOR_GREEN_UP;
         sec_base = 9'd60;
      end else begin
         sec3_in  = hsv2rgb_pkg::SECTOR_RED_UP;
         sec_base = 9'd0;
      end
   end

   // Position within the sector, reflected in odd sectors
   assign deg_in_sec = 6'(qm2_ff - sec_base);
   assign pos        = (KW'(deg_in_sec) << HUE_FRAC_BITS) | KW'(frac2_ff);
   assign k3_in      = sec3_in[0] ? KW'(SEC_W) - pos : pos;
   assign low_prod   = 33'(y2_ff) * 33'(hsv2rgb_pkg::LOW_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sec3_ff  <= sec3_in;
         k3_ff    <= k3_in;
         lowq3_ff <= low_prod[LS+7:LS];
         y3_ff    <= y2_ff;
         s3_ff    <= s2_ff;
         v3_ff    <= v2_ff;
      end
   end

   // ---------------- Stage 4: ramp numerator n, low channel correction
   logic [15:0]   low_rem;
   logic [7:0]    low4_in;
   logic [13:0]   n_base;
   logic [NW-1:0] n4_in;
   logic [NW-1:0] n4_ff;
   logic [7:0]    low4_ff;
   hsv2rgb_pkg::sector_type sec4_ff;
   logic [7:0]    v4_ff;

   assign low_rem = y3_ff - 16'(lowq3_ff) * 16'(hsv2rgb_pkg::FULL_SCALE);
   assign low4_in = (low_rem >= 16'(hsv2rgb_pkg::FULL_SCALE)) ? lowq3_ff + 8'd1 : lowq3_ff;
   assign n_base  = 14'(8'(8'd255 - s3_ff)) * 14'(hsv2rgb_pkg::DEG_SECTOR);
   assign n4_in   = (NW'(n_base) << HUE_FRAC_BITS) + NW'(s3_ff) * NW'(k3_ff);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         n4_ff   <= n4_in;
         low4_ff <= low4_in;
         sec4_ff <= sec3_ff;
         v4_ff   <= v3_ff;
      end
   end

   // ---------------- Stage 5: v*n, drop the hue fraction scale
   logic [PW-1:0] vn_prod;
   logic [XW-1:0] x5_ff;
   logic [7:0]    low5_ff;
   hsv2rgb_pkg::sector_type sec5_ff;
   logic [7:0]    v5_ff;

   assign vn_prod = PW'(v4_ff) * PW'(n4_ff);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         x5_ff   <= XW'(vn_prod >> HUE_FRAC_BITS);
         low5_ff <= low4_ff;
         sec5_ff <= sec4_ff;
         v5_ff   <= v4_ff;
      end
   end

   // ---------------- Stage 6: ramp quotient estimate
   logic [39:0]   ramp_prod;
   logic [7:0]    rq6_ff;
   logic [XW-1:0] x6_ff;
   logic [7:0]    low6_ff;
   hsv2rgb_pkg::sector_type sec6_ff;
   logic [7:0]    v6_ff;

   assign ramp_prod = 40'(x5_ff) * 40'(hsv2rgb_pkg::RAMP_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         rq6_ff  <= ramp_prod[RS+7:RS];
         x6_ff   <= x5_ff;
         low6_ff <= low5_ff;
         sec6_ff <= sec5_ff;
         v6_ff   <= v5_ff;
      end
   end

   // ---------------- Stage 7: ramp correction and channel routing
   logic [XW-1:0] ramp_rem;
   logic [7:0]    ramp;
   hsv2rgb_pkg::rsp_word_type rsp_data_in;
   hsv2rgb_pkg::rsp_word_type rsp_data_ff;

   assign ramp_rem = x6_ff - XW'(rq6_ff) * XW'(hsv2rgb_pkg::RAMP_DIV);
   assign ramp     = (ramp_rem >= XW'(hsv2rgb_pkg::RAMP_DIV)) ? rq6_ff + 8'd1 : rq6_ff;

   always_comb begin
      unique case (sec6_ff)
         hsv2rgb_pkg::SECTOR_RED_UP:   rsp_data_in = '{red: v6_ff,   green: ramp,    blue: low6_ff};
         hsv2rgb_pkg::SECTOR_GREEN_UP: rsp_data_in = '{red: ramp,    green: v6_ff,   blue: low6_ff};
         hsv2rgb_pkg::SECTOR_GREEN_DN: rsp_data_in = '{red: low6_ff, green: v6_ff,   blue: ramp};
         hsv2rgb_pkg::SECTOR_BLUE_UP:  rsp_data_in = '{red: low6_ff, green: ramp,    blue: v6_ff};
         hsv2rgb_pkg::SECTOR_BLUE_DN:  rsp_data_in = '{red: ramp,    green: low6_ff, blue: v6_ff};
         default:                      rsp_data_in = '{red: v6_ff,   green: low6_ff, blue: ramp};
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // ---------------- Checks
   `HSV_ASSERT_IMPLY(a_hue_reduced, clock, reset, stage_vld_ff[2], qm2_ff < 9'd360)
   `HSV_ASSERT_IMPLY(a_low_est_close, clock, reset, stage_vld_ff[3], low_rem < 16'd510)
   `HSV_ASSERT_IMPLY(a_ramp_est_close, clock, reset, stage_vld_ff[6], ramp_rem < XW'(30600))
   `HSV_ASSERT_NEXT(a_stage_holds, clock, reset, stage_vld_ff[6] && !stage_en[6], stage_vld_ff[6])
   `HSV_ASSERT_IMPLY(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

// File: dv/hsv_to_rgb_convert_tb.sv
// Self-checking testbench of hsv_to_rgb_convert: directed and random HSV pixels.
// Holds its own hexcone prediction; depends on hsv2rgb_pkg and the block RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_convert_tb;

   localparam int unsigned HUE_FRAC_BITS = 6;
   localparam int unsigned HUE_TURN      = hsv2rgb_pkg::DEG_TURN << HUE_FRAC_BITS;
   localparam int unsigned HUE_SECTOR    = hsv2rgb_pkg::DEG_SECTOR << HUE_FRAC_BITS;
   localparam int unsigned FULL_SCALE    = hsv2rgb_pkg::FULL_SCALE;
   localparam int unsigned RANDOM_PIXELS = 1250;
   localparam int unsigned IDLE_PCT      = 27;
   localparam int unsigned HOLDOFF_LEN   = 80;
   localparam int unsigned SETTLE_CYCLES = 16;

   // One entry of the send list: a pixel, or a pause until all results are back
   typedef struct {
      hsv2rgb_pkg::req_word_type word;
      bit                        drain;
   } pixel_slot_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   hsv2rgb_pkg::req_word_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   hsv2rgb_pkg::rsp_word_type rsp_data;

   pixel_slot_type            pixel_send_q[$];
   hsv2rgb_pkg::rsp_word_type rgb_expect_q[$];
   int unsigned    words_sent     = 0;
   int unsigned    words_checked  = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    holdoff_left   = 0;
   bit             holdoff_done   = 1'b0;

   hsv_to_rgb_convert #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Exact hexcone conversion: sector, reflected position, three channel roles
   function automatic hsv2rgb_pkg::rsp_word_type hsv_to_rgb_predict(
      hsv2rgb_pkg::req_word_type px);
      int unsigned  h;
      int unsigned  s;
      int unsigned  v;
      int unsigned  pos;
      int unsigned  k;
      int unsigned  top;
      int unsigned  low;
      int unsigned  ramp;
      hsv2rgb_pkg::sector_type   sec;
      hsv2rgb_pkg::rsp_word_type rgb;
      h    = int'(px.hue) % HUE_TURN;
      s    = px.saturation;
      v    = px.brightness;
      sec  = hsv2rgb_pkg::sector_type'(h / HUE_SECTOR);
      pos  = h % HUE_SECTOR;
      k    = ((h / HUE_SECTOR) % 2 == 1) ? HUE_SECTOR - pos : pos;
      top  = v;
      low  = (v * (FULL_SCALE - s)) / FULL_SCALE;
      ramp = (v * (HUE_SECTOR * (FULL_SCALE - s) + s * k)) / (FULL_SCALE * HUE_SECTOR);
      unique case (sec)
         hsv2rgb_pkg::SECTOR_RED_UP: begin
            rgb.red = top[7:0];  rgb.green = ramp[7:0]; rgb.blue = low[7:0];
         end
         hsv2rgb_pkg::SECTOR_GREEN_UP: begin
            rgb.red = ramp[7:0]; rgb.green = top[7:0];  rgb.blue = low[7:0];
         end
         hsv2rgb_pkg::SECTOR_GREEN_DN: begin
            rgb.red = low[7:0];  rgb.green = top[7:0];  rgb.blue = ramp[7:0];
         end
         hsv2rgb_pkg::SECTOR_BLUE_UP: begin
            rgb.red = low[7:0];  rgb.green = ramp[7:0]; rgb.blue = top[7:0];
         end
         hsv2rgb_pkg::SECTOR_BLUE_DN: begin
            rgb.red = ramp[7:0]; rgb.green = low[7:0];  rgb.blue = top[7:0];
         end
         default: begin
            rgb.red = top[7:0];  rgb.green = low[7:0];  rgb.blue = ramp[7:0];
         end
      endcase
      return rgb;
   endfunction

   task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val);
      pixel_slot_type slot;
      slot.word.hue        = hue[15:0];
      slot.word.saturation = sat[7:0];
      slot.word.brightness = val[7:0];
      slot.drain           = 1'b0;
      pixel_send_q.push_back(slot);
   endtask

   task automatic add_drain();
      pixel_slot_type slot;
      slot.word  = '0;
      slot.drain = 1'b1;
      pixel_send_q.push_back(slot);
   endtask

   // Random byte that lands on either extreme now and then
   function automatic int unsigned pick_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) return 0;
      if (roll < 24) return 255;
      return $urandom_range(255);
   endfunction

   // Driver: offers the next word when the previous one has gone
   always @(posedge clock) begin
      logic           next_valid;
      logic           accepted;
      pixel_slot_type slot;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            rgb_expect_q.push_back(hsv_to_rgb_predict(req_data));
            words_sent++;
         end
         if (!req_valid || accepted) begin
            next_valid = 1'b0;
            if (pixel_send_q.size() > 0) begin
               if (pixel_send_q[0].drain) begin
                  // sender pause: resume once every result is back
                  if (rgb_expect_q.size() == 0)
                     void'(pixel_send_q.pop_front());
               end else if ((words_sent >= 300 && words_sent < 500)
                            || $urandom_range(99) >= IDLE_PCT) begin
                  next_valid = 1'b1;
                  slot = pixel_send_q.pop_front();
                  req_data <= slot.word;
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // Long receiver hold-off, once, so the pipe fills and stalls its input
   always @(posedge clock) begin
      if (!reset) begin
         if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
         end else if (!holdoff_done && words_checked >= 800) begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
         end
      end
   end

   // Receiver stall: random, calm stretch, or hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (holdoff_left > 1)
            || (!(words_checked >= 300 && words_checked < 500)
                && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      hsv2rgb_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rgb_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: r=%0d g=%0d b=%0d",
                        rsp_data.red, rsp_data.green, rsp_data.blue);
         end else begin
            want = rgb_expect_q.pop_front();
            words_checked++;
            if (rsp_data.red !== want.red || rsp_data.green !== want.green
                || rsp_data.blue !== want.blue) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at word %0d: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                           words_checked, want.red, want.green, want.blue,
                           rsp_data.red, rsp_data.green, rsp_data.blue);
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int unsigned hue;
      int unsigned roll;
      // directed: sector edges, wrap, odd sector start, extremes
      add_pixel(0, 255, 255);
      add_pixel(HUE_SECTOR - 1, 255, 255);
      add_pixel(HUE_SECTOR, 255, 255);
      add_pixel(2 * HUE_SECTOR, 200, 180);
      add_pixel(3 * HUE_SECTOR, 255, 255);
      add_pixel(4 * HUE_SECTOR + 1, 128, 255);
      add_pixel(5 * HUE_SECTOR, 255, 100);
      add_pixel(HUE_TURN - 1, 255, 255);
      add_pixel(HUE_TURN, 255, 255);
      add_pixel(HUE_TURN + HUE_SECTOR, 77, 199);
      add_pixel(65535, 255, 255);
      add_pixel(65535, 0, 0);
      add_pixel(HUE_SECTOR / 2, 0, 200);
      add_pixel(HUE_SECTOR / 2, 255, 0);
      add_pixel(HUE_SECTOR / 2 + HUE_SECTOR, 1, 254);
      add_pixel(HUE_SECTOR / 2 + 2 * HUE_SECTOR, 254, 1);
      add_pixel(HUE_SECTOR / 2 + 3 * HUE_SECTOR, 170, 85);
      add_pixel(HUE_SECTOR / 2 + 4 * HUE_SECTOR, 85, 170);
      add_pixel(HUE_SECTOR / 2 + 5 * HUE_SECTOR, 255, 255);
      add_pixel(21845, 255, 255);
      add_pixel(43690, 170, 85);
      add_drain();
      // random: full hue range, one turn, and sector edges
      for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
         roll = $urandom_range(99);
         if (roll < 45)
            hue = $urandom_range(65535);
         else if (roll < 75)
            hue = $urandom_range(HUE_TURN - 1);
         else
            hue = $urandom_range(5) * HUE_SECTOR + $urandom_range(2) * (HUE_SECTOR - 1)
                  + $urandom_range(1) * HUE_TURN * $urandom_range(1);
         add_pixel(hue, pick_byte(), pick_byte());
         if (n == 600)
            add_drain();
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // wait for the last word to go out and its result to come back
      do
         @(posedge clock);
      while (pixel_send_q.size() > 0 || req_valid || rgb_expect_q.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rgb_expect_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Run limit
   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

// File: hsv_to_rgb_convert.f
+incdir+design
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_convert.sv
dv/hsv_to_rgb_convert_tb.sv
